>>> sv/pwm_generator_time_sliced_macros.svh
// Assertion helpers used by the PWM generator controller
`ifndef PWM_GENERATOR_TIME_SLICED_MACROS_SVH
`define PWM_GENERATOR_TIME_SLICED_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PGTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgts same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PGTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgts next-cycle check failed");

`endif

>>> sv/pgts_pkg.sv
package pgts_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam int CFG_W       = 32;
  localparam int STEPS_W     = 16;
  localparam int DUTY_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_W-1:0]   PERIOD_RST = 32'd1000;
  localparam logic [CFG_W-1:0]   MAX_ON_RST = 32'd1000;
  localparam logic [CFG_W-1:0]   MIN_ON_RST = 32'd0;
  localparam logic [STEPS_W-1:0] STEPS_RST  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_MAX_ON = 2'd1,
    REG_MIN_ON = 2'd2,
    REG_STEPS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;     // latch the incoming word
    logic eval;     // apply tick rules, or kick off the divide
    logic div_fin;  // divide finished: toggle phase and reload counter
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

>>> sv/pwm_generator_time_sliced.sv
// Time-sliced PWM generator. Each word on the input stream is one PWM tick carrying the
// requested duty level; each tick returns exactly one word with the pin level after the
// tick and the config_ok flag. One tick is worked at a time: a tick that keeps its phase or
// is forced on/off returns its result through the EVAL and OUT states, and the block is ready
// again the cycle after the result is taken. A tick that toggles the phase recomputes the on
// span in the DIV state with a serial restoring divider, one quotient bit per cycle over
// min(TIME_WIDTH,32)+16 dividend bits. Configuration writes must be issued only while no
// tick is in flight; each one restarts the generator in the off phase.
module pwm_generator_time_sliced #(
  parameter int TIME_WIDTH = pgts_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pgts_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] duty_level
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pgts_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] pin_level, [1] config_ok
  input  logic                                cfg_we,
  input  logic [pgts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pgts_pkg::CFG_W-1:0]          cfg_wdata
);

  pgts_pkg::ctrl_cmd_t cmd;
  pgts_pkg::dp_stat_t  stat;
  logic                pin_level;
  logic                config_ok;

  pgts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  pgts_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_duty   (in_tdata[pgts_pkg::DUTY_W-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .pin_level (pin_level),
    .config_ok (config_ok)
  );

  assign out_tdata = {{(pgts_pkg::OUT_TDATA_W - 2){1'b0}}, config_ok, pin_level};

endmodule

>>> sv/pgts_div.sv
module pgts_div #(
  parameter int NW  = 48,
  parameter int DVW = 16,
  parameter int QW  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [QW-1:0]  quotient,
  output logic           done
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    sh_r;
  logic [DVW-1:0]   rem_r;
  logic [DVW-1:0]   dvs_r;

  logic [DVW:0]   trial;
  logic [DVW:0]   trial_sub;
  logic           ge;
  logic [DVW-1:0] rem_nxt;

  // restoring step: one quotient bit per cycle, shifted in where dividend bits leave
  always_comb begin
    trial     = {rem_r, sh_r[NW-1]};
    ge        = trial >= {1'b0, dvs_r};
    trial_sub = trial - {1'b0, dvs_r};
    rem_nxt   = ge ? trial_sub[DVW-1:0] : trial[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= {sh_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = sh_r[QW-1:0];
  assign done     = done_r;

endmodule

>>> sv/pgts_dp.sv
module pgts_dp #(
  parameter int TIME_WIDTH = pgts_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pgts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pgts_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [pgts_pkg::DUTY_W-1:0]         in_duty,
  input  pgts_pkg::ctrl_cmd_t                 cmd,
  output pgts_pkg::dp_stat_t                  stat,
  output logic                                pin_level,
  output logic                                config_ok
);

  // config values are 32 bits; tick arithmetic sees them modulo 2^TIME_WIDTH
  localparam int CW = (TIME_WIDTH < pgts_pkg::CFG_W) ? TIME_WIDTH : pgts_pkg::CFG_W;
  localparam int NW = CW + pgts_pkg::DUTY_W;

  logic [pgts_pkg::CFG_W-1:0]   period_r;
  logic [pgts_pkg::CFG_W-1:0]   max_on_r;
  logic [pgts_pkg::CFG_W-1:0]   min_on_r;
  logic [pgts_pkg::STEPS_W-1:0] steps_r;
  logic                         phase_r;
  logic [TIME_WIDTH-1:0]        ticks_r;

  logic [pgts_pkg::DUTY_W-1:0]  duty_r;
  logic [CW-1:0]                diff_r;

  logic [CW-1:0]         hi;
  logic [CW-1:0]         lo;
  logic [CW-1:0]         per;
  logic [TIME_WIDTH-1:0] per_ext;
  logic [TIME_WIDTH-1:0] tl_dec;
  logic                  force_on;
  logic                  force_off;
  logic [NW-1:0]         product;
  logic                  div_start;
  logic [CW-1:0]         quo;
  logic                  div_done;
  logic [TIME_WIDTH-1:0] on_span;
  logic [TIME_WIDTH-1:0] off_span;

  always_comb begin
    hi        = max_on_r[CW-1:0];
    lo        = min_on_r[CW-1:0];
    per       = period_r[CW-1:0];
    per_ext   = TIME_WIDTH'(per);
    tl_dec    = (ticks_r != '0) ? ticks_r - TIME_WIDTH'(1) : ticks_r;
    force_on  = duty_r >= steps_r;
    force_off = duty_r == '0;
    product   = NW'(diff_r) * NW'(duty_r);
    on_span   = TIME_WIDTH'(quo);
    off_span  = (per_ext > on_span) ? per_ext - on_span : '0;
    config_ok = (per >= hi) && (hi > lo) && (steps_r != '0);
  end

  assign stat.need_div = !force_on && !force_off && (tl_dec == '0);
  assign stat.div_done = div_done;
  assign div_start     = cmd.eval && stat.need_div;
  assign pin_level     = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= pgts_pkg::PERIOD_RST;
      max_on_r <= pgts_pkg::MAX_ON_RST;
      min_on_r <= pgts_pkg::MIN_ON_RST;
      steps_r  <= pgts_pkg::STEPS_RST;
      phase_r  <= 1'b0;
      ticks_r  <= '0;
    end else if (cfg_we) begin
      // any register write restarts the generator
      phase_r <= 1'b0;
      ticks_r <= '0;
      case (pgts_pkg::cfg_reg_t'(cfg_index))
        pgts_pkg::REG_PERIOD: period_r <= cfg_wdata;
        pgts_pkg::REG_MAX_ON: max_on_r <= cfg_wdata;
        pgts_pkg::REG_MIN_ON: min_on_r <= cfg_wdata;
        pgts_pkg::REG_STEPS:  steps_r  <= cfg_wdata[pgts_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end else if (cmd.eval) begin
      ticks_r <= tl_dec;
      if (force_on) begin
        phase_r <= 1'b1;
      end else if (force_off) begin
        phase_r <= 1'b0;
      end
    end else if (cmd.div_fin) begin
      phase_r <= !phase_r;
      ticks_r <= phase_r ? off_span : on_span;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      duty_r <= in_duty;
      diff_r <= (hi > lo) ? hi - lo : '0;
    end
  end

  // duty < steps here, so the quotient stays below diff and fits CW bits
  pgts_div #(
    .NW  (NW),
    .DVW (pgts_pkg::STEPS_W),
    .QW  (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (steps_r),
    .quotient (quo),
    .done     (div_done)
  );

endmodule

>>> sv/pgts_ctrl.sv
module pgts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  pgts_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output logic                out_valid,
  output pgts_pkg::ctrl_cmd_t cmd
);

  pgts_pkg::state_t state_r;
  pgts_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      pgts_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = pgts_pkg::ST_EVAL;
        end
      end
      pgts_pkg::ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.need_div ? pgts_pkg::ST_DIV : pgts_pkg::ST_OUT;
      end
      pgts_pkg::ST_DIV: begin
        if (stat.div_done) begin
          cmd.div_fin = 1'b1;
          state_nxt   = pgts_pkg::ST_OUT;
        end
      end
      pgts_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = pgts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = state_r == pgts_pkg::ST_IDLE;
  assign out_valid = state_r == pgts_pkg::ST_OUT;

`include "pwm_generator_time_sliced_macros.svh"

  `PGTS_ASSERT_NEXT(a_accept_eval, clk, rst_n, in_valid && in_ready, state_r == pgts_pkg::ST_EVAL)
  `PGTS_ASSERT_NEXT(a_div_wait, clk, rst_n, (state_r == pgts_pkg::ST_DIV) && !stat.div_done, state_r == pgts_pkg::ST_DIV)
  `PGTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `PGTS_ASSERT_IMPL(a_done_in_div, clk, rst_n, stat.div_done, state_r == pgts_pkg::ST_DIV)

endmodule

>>> verif/pwm_generator_time_sliced_tb.sv
`timescale 1ns / 1ps

module pwm_generator_time_sliced_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int DW             = pgts_pkg::DUTY_W;

  typedef struct packed {
    logic pin;
    logic cfg_ok;
  } pin_word_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [pgts_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] duty_level
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [pgts_pkg::OUT_TDATA_W-1:0] out_tdata;       // [0] pin_level, [1] config_ok
  logic                             cfg_we = 1'b0;
  logic [pgts_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [pgts_pkg::CFG_W-1:0]       cfg_wdata = '0;

  // predictor copy of registers and generator state
  logic [pgts_pkg::CFG_W-1:0]   pwm_period = pgts_pkg::PERIOD_RST;
  logic [pgts_pkg::CFG_W-1:0]   pwm_max_on = pgts_pkg::MAX_ON_RST;
  logic [pgts_pkg::CFG_W-1:0]   pwm_min_on = pgts_pkg::MIN_ON_RST;
  logic [pgts_pkg::STEPS_W-1:0] pwm_steps  = pgts_pkg::STEPS_RST;
  logic                         pwm_phase  = 1'b0;
  logic [31:0]                  pwm_ticks_left = '0;

  pin_word_t   pin_queue[$];
  int unsigned mismatches = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  pwm_generator_time_sliced DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // one tick: counter steps down, forced levels, else toggle and reload span
  function automatic void predict_tick(input logic [DW-1:0] duty);
    logic [63:0] diff;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] on_len;
    logic [31:0] on32;
    pin_word_t   w;
    if (pwm_ticks_left != 0) pwm_ticks_left = pwm_ticks_left - 1;
    if (duty >= pwm_steps) begin
      pwm_phase = 1'b1;
    end else if (duty == 0) begin
      pwm_phase = 1'b0;
    end else if (pwm_ticks_left == 0) begin
      diff = (pwm_max_on > pwm_min_on) ? 64'(pwm_max_on) - 64'(pwm_min_on) : 64'd0;
      quo = diff / 64'(pwm_steps);
      rem = diff % 64'(pwm_steps);
      on_len = quo * 64'(duty) + (rem * 64'(duty)) / 64'(pwm_steps);
      on32 = on_len[31:0];
      if (pwm_phase) begin
        pwm_phase = 1'b0;
        pwm_ticks_left = (pwm_period > on32) ? pwm_period - on32 : 32'd0;
      end else begin
        pwm_phase = 1'b1;
        pwm_ticks_left = on32;
      end
    end
    w.pin = pwm_phase;
    w.cfg_ok = (pwm_period >= pwm_max_on) && (pwm_max_on > pwm_min_on) && (pwm_steps != 0);
    pin_queue.push_back(w);
  endfunction

  function automatic logic [DW-1:0] random_duty();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) return DW'($urandom);
    if (pick < 13) return '0;
    if (pick < 20 || pwm_steps < 2) return DW'($urandom_range(65535, pwm_steps));
    return DW'($urandom_range(pwm_steps - 1, 1));
  endfunction

  task automatic send_tick(input logic [DW-1:0] duty);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= duty;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tick(duty);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pin_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input pgts_pkg::cfg_reg_t idx,
                           input logic [pgts_pkg::CFG_W-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pgts_pkg::REG_PERIOD: pwm_period = val;
      pgts_pkg::REG_MAX_ON: pwm_max_on = val;
      pgts_pkg::REG_MIN_ON: pwm_min_on = val;
      pgts_pkg::REG_STEPS:  pwm_steps  = val[pgts_pkg::STEPS_W-1:0];
      default: ;
    endcase
    // any write restarts the generator in the off phase
    pwm_phase = 1'b0;
    pwm_ticks_left = '0;
  endtask

  task automatic set_config(input logic [pgts_pkg::CFG_W-1:0] period,
                            input logic [pgts_pkg::CFG_W-1:0] hi,
                            input logic [pgts_pkg::CFG_W-1:0] lo,
                            input logic [pgts_pkg::CFG_W-1:0] steps);
    write_reg(pgts_pkg::REG_PERIOD, period);
    write_reg(pgts_pkg::REG_MAX_ON, hi);
    write_reg(pgts_pkg::REG_MIN_ON, lo);
    write_reg(pgts_pkg::REG_STEPS, steps);
  endtask

  task automatic set_random_config();
    logic [pgts_pkg::CFG_W-1:0] hi;
    logic [pgts_pkg::CFG_W-1:0] lo;
    if ($urandom_range(99) < 65) begin
      set_config($urandom_range(24), $urandom_range(20), $urandom_range(12),
                 $urandom_range(9, 1));
    end else begin
      // wide operands, but often a small span so toggles keep coming
      hi = $urandom;
      lo = $urandom_range(1) ? $urandom : hi - $urandom_range(64);
      set_config($urandom_range(1) ? $urandom : (hi - lo) + $urandom_range(64), hi, lo,
                 $urandom);
    end
  endtask

  task automatic test_default_config();
    snd_idle_pct = 15;
    rcv_idle_pct = 47;
    send_tick(16'd1);
    send_tick(16'd1);
    send_tick(16'd1);
    send_tick(16'd0);
    send_tick(16'd100);
    send_tick(16'hFFFF);
    send_tick(16'd99);
  endtask

  task automatic test_short_period();
    set_config(32'd4, 32'd3, 32'd0, 32'd2);
    repeat (6) send_tick(16'd1);
  endtask

  task automatic test_zero_steps();
    // every duty counts as full on
    set_config(32'd5, 32'd0, 32'd0, 32'd0);
    send_tick(16'd0);
    send_tick(16'd5);
  endtask

  task automatic test_min_above_max();
    // on span saturates at zero, still lasts one tick
    set_config(32'd3, 32'd2, 32'hFFFF_FFFF, 32'd4);
    repeat (3) send_tick(16'd2);
  endtask

  task automatic test_span_over_period();
    set_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF);
    repeat (3) send_tick(16'hFFFE);
  endtask

  task automatic test_wide_values();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1);
    send_tick(16'h8000);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF);
    send_tick(16'h7FFF);
  endtask

  task automatic test_backpressure();
    set_config(32'd6, 32'd5, 32'd1, 32'd3);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (24) send_tick(random_duty());
    wait_drained();
    repeat (20) send_tick(random_duty());
  endtask

  task automatic run_random_phase(input int unsigned snd, input int unsigned rcv,
                                  input int unsigned n_cfg, input int unsigned n_items);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    repeat (n_cfg) begin
      set_random_config();
      repeat (n_items) send_tick(random_duty());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(15, 47, 10, 40);
    run_random_phase(47, 15, 10, 40);
    run_random_phase(0, 0, 10, 40);
  endtask

  // result sink: random stalls, plus a long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    pin_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pin_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = pin_queue.pop_front();
          if (out_tdata[0] !== want.pin || out_tdata[1] !== want.cfg_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: pin exp %b got %b, config_ok exp %b got %b",
                       want.pin, out_tdata[0], want.cfg_ok, out_tdata[1]);
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_short_period();
    test_zero_steps();
    test_min_above_max();
    test_span_over_period();
    test_wide_values();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pin_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
